@@ rtl/core/orgu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orgu_pkg
// Shared types and constants for the occupancy ray grid update block.
// ----------------------------------------------------------------------------
package orgu_pkg;

    localparam int GRID_COLS      = 256;
    localparam int GRID_ROWS      = 256;
    localparam int CELL_COUNT     = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W         = $clog2(CELL_COUNT);
    localparam int CERT_W         = 4;
    localparam int CNT_W          = 9;
    localparam int COORD_W        = 8;
    localparam int OCC_STEP       = 3;
    localparam int CERT_MAX       = 15;
    localparam int WALL_OLD_LIMIT = 12;

    typedef enum logic [1:0] {
        CMD_RAY  = 2'd0,
        CMD_OCC  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_WALK  = 2'd2,
        ST_OUT   = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0]         command;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic [CERT_W-1:0] certainty;
        logic              visited;
        logic              wall;
        logic [CNT_W-1:0]  cells_written;
    } t_out_item;

    // line endpoints handed to the walker
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
    } t_ray;

    // one cell of the line, one per cycle
    typedef struct packed {
        logic               vld;
        logic               last;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_walk_cell;

    typedef struct packed {
        logic [CERT_W-1:0] cert;
        logic              vis;
        logic              wall;
    } t_cell;

endpackage

@@ rtl/core/orgu_walker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orgu_walker
// Bresenham line stepper: one shared error adder advances one cell a cycle.
// ----------------------------------------------------------------------------
module orgu_walker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  orgu_pkg::t_ray      i_ray,
    output orgu_pkg::t_walk_cell o_cell
);
    import orgu_pkg::*;

    localparam int P_W = COORD_W + 3;

    logic                  r_busy;
    logic [COORD_W-1:0]    r_x, r_y, r_ex, r_ey;
    logic                  r_sx_neg, r_sy_neg, r_xmajor;
    logic signed [P_W-1:0] r_p, r_inc_s, r_inc_d;

    logic signed [COORD_W:0] w_dx_s, w_dy_s;
    logic [COORD_W-1:0]      w_adx, w_ady, w_maj, w_min;
    logic                    w_xmajor;
    logic signed [P_W-1:0]   w_two_min, w_two_maj, w_maj_s;
    logic                    w_last, w_diag;
    logic signed [P_W-1:0]   n_p;
    logic [COORD_W-1:0]      n_x, n_y;

    always_comb begin
        w_dx_s    = $signed({1'b0, i_ray.x1}) - $signed({1'b0, i_ray.x0});
        w_dy_s    = $signed({1'b0, i_ray.y1}) - $signed({1'b0, i_ray.y0});
        w_adx     = w_dx_s[COORD_W] ? COORD_W'(-w_dx_s) : w_dx_s[COORD_W-1:0];
        w_ady     = w_dy_s[COORD_W] ? COORD_W'(-w_dy_s) : w_dy_s[COORD_W-1:0];
        w_xmajor  = w_adx > w_ady;
        w_maj     = w_xmajor ? w_adx : w_ady;
        w_min     = w_xmajor ? w_ady : w_adx;
        w_two_min = $signed(P_W'({w_min, 1'b0}));
        w_two_maj = $signed(P_W'({w_maj, 1'b0}));
        w_maj_s   = $signed(P_W'(w_maj));
    end

    // shared error adder and coordinate step
    always_comb begin
        w_last = r_xmajor ? (r_x == r_ex) : (r_y == r_ey);
        w_diag = !r_p[P_W-1];
        n_p    = r_p + (w_diag ? r_inc_d : r_inc_s);
        n_x    = r_x;
        n_y    = r_y;
        if (r_xmajor || w_diag) begin
            n_x = r_sx_neg ? r_x - 1'b1 : r_x + 1'b1;
        end
        if (!r_xmajor || w_diag) begin
            n_y = r_sy_neg ? r_y - 1'b1 : r_y + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x      <= i_ray.x0;
            r_y      <= i_ray.y0;
            r_ex     <= i_ray.x1;
            r_ey     <= i_ray.y1;
            r_sx_neg <= w_dx_s[COORD_W];
            r_sy_neg <= w_dy_s[COORD_W];
            r_xmajor <= w_xmajor;
            r_p      <= w_two_min - w_maj_s;
            r_inc_s  <= w_two_min;
            r_inc_d  <= w_two_min - w_two_maj;
        end else if (r_busy && !w_last) begin
            r_x <= n_x;
            r_y <= n_y;
            r_p <= n_p;
        end
    end

    assign o_cell = '{vld: r_busy, last: w_last, x: r_x, y: r_y};

endmodule

@@ rtl/core/occupancy_ray_grid_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_ray_grid_update
// Occupancy grid with free-ray tracing, occupied marking and cell readback.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one command per
// transfer; output channel (o_out_valid / i_out_stall / o_out_data) gives
// exactly one result per command.
// After reset the grid memory is cleared one cell per cycle, all
// GRID_COLS * GRID_ROWS cells; o_in_stall stays high until the pass is done.
// A command is worked on alone: o_in_stall is high from its transfer until
// its result has been taken.
// A ray walks every cell from its start to its end, up to 256 cells;
// single-cell commands walk one cell and the unused command code 3 none. The
// walker emits one cell a cycle and the grid memory does one read-modify-write
// per cell, with the read of the next cell overlapped with the write of the
// previous one.
// The result is held in registers while i_out_stall is high; no new command
// is taken until it has been transferred.
// ----------------------------------------------------------------------------
module occupancy_ray_grid_update (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  orgu_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output orgu_pkg::t_out_item o_out_data
);
    import orgu_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_cmd, w_in_cmd;

    logic [ADDR_W-1:0] r_clr_addr;
    logic              w_clr_last, w_clr_we, w_accept, w_start;

    t_ray       w_ray;
    t_walk_cell w_cell;

    logic              w_cell_in;
    logic [ADDR_W-1:0] w_rd_addr;

    t_cell r_mem [CELL_COUNT];
    t_cell r_rdata;

    logic              r_p1_vld, r_p1_in, r_p1_last;
    logic [ADDR_W-1:0] r_p1_addr;

    logic [CERT_W-1:0] w_old, w_nv;
    logic [CERT_W:0]   w_sum;
    logic              w_wall_new, w_upd, w_upd_we;
    t_cell             w_new_cell;

    logic [CERT_W-1:0] r_cert;
    logic              r_vis, r_wall;
    logic [CNT_W-1:0]  r_cnt;

    assign w_in_cmd   = t_cmd'(i_in_data.command);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_clr_last = r_clr_addr == ADDR_W'(CELL_COUNT - 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (w_clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_in_cmd == CMD_NONE) ? ST_OUT : ST_WALK;
                end
            end
            ST_WALK:  if (r_p1_vld && r_p1_last) n_state = ST_OUT;
            ST_OUT:   if (!i_out_stall) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        w_clr_we    = 1'b0;
        case (r_state)
            ST_CLEAR: w_clr_we = 1'b1;
            ST_IDLE:  o_in_stall = 1'b0;
            ST_WALK:  o_in_stall = 1'b1;
            ST_OUT:   o_out_valid = 1'b1;
            default:  o_in_stall = 1'b1;
        endcase
    end

    assign w_start = w_accept && (w_in_cmd != CMD_NONE);

    // single-cell commands walk a line of one cell
    always_comb begin
        w_ray.x0 = i_in_data.start_x;
        w_ray.y0 = i_in_data.start_y;
        w_ray.x1 = (w_in_cmd == CMD_RAY) ? i_in_data.end_x : i_in_data.start_x;
        w_ray.y1 = (w_in_cmd == CMD_RAY) ? i_in_data.end_y : i_in_data.start_y;
    end

    orgu_walker u_walker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_ray   (w_ray),
        .o_cell  (w_cell)
    );

    assign w_cell_in = (int'(w_cell.x) < GRID_COLS) && (int'(w_cell.y) < GRID_ROWS);
    assign w_rd_addr = ADDR_W'(int'(w_cell.y) * GRID_COLS + int'(w_cell.x));

    // update of the cell read in the previous cycle
    always_comb begin
        w_old = r_rdata.cert;
        w_sum = {1'b0, w_old} + (CERT_W + 1)'(OCC_STEP);
        if (r_cmd == CMD_OCC) begin
            w_nv = (w_sum > (CERT_W + 1)'(CERT_MAX)) ? CERT_W'(CERT_MAX)
                                                     : w_sum[CERT_W-1:0];
        end else begin
            w_nv = (w_old == '0) ? '0 : w_old - 1'b1;
        end
        w_wall_new = r_rdata.wall || (w_nv == CERT_W'(CERT_MAX))
                     || (w_old > CERT_W'(WALL_OLD_LIMIT));
        w_new_cell = '{cert: w_nv, vis: 1'b1, wall: w_wall_new};
        w_upd      = r_p1_vld && r_p1_in;
        w_upd_we   = w_upd && (r_cmd != CMD_READ);
    end

    always_ff @(posedge i_clk) begin
        if (w_clr_we) begin
            r_mem[r_clr_addr] <= '0;
        end else if (w_upd_we) begin
            r_mem[r_p1_addr] <= w_new_cell;
        end
        if (w_cell.vld && w_cell_in) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_p1_vld   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= w_cell.vld;
            if (w_clr_we) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_in   <= w_cell_in;
        r_p1_last <= w_cell.last;
        r_p1_addr <= w_rd_addr;
        if (w_accept) begin
            r_cmd  <= w_in_cmd;
            r_cert <= '0;
            r_vis  <= 1'b0;
            r_wall <= 1'b0;
            r_cnt  <= '0;
        end else if (w_upd) begin
            if (r_cmd == CMD_READ) begin
                r_cert <= r_rdata.cert;
                r_vis  <= r_rdata.vis;
                r_wall <= r_rdata.wall;
            end else begin
                r_cert <= w_nv;
                r_vis  <= 1'b1;
                r_wall <= w_wall_new;
                r_cnt  <= r_cnt + 1'b1;
            end
        end
    end

    assign o_out_data = '{certainty: r_cert, visited: r_vis, wall: r_wall,
                          cells_written: r_cnt};

endmodule

@@ rtl/core/orgu_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orgu_checker
// Port-level checks for the occupancy ray grid update block.
// ----------------------------------------------------------------------------
module orgu_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  orgu_pkg::t_in_item  i_in_data,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  orgu_pkg::t_out_item o_out_data
);
    import orgu_pkg::*;

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // one command at a time: no transfer while a result waits
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // a transfer in closes the input on the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not closed after transfer");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.cells_written <= CNT_W'(256))
        else $error("cells_written out of range");

    // any updated cell is marked visited
    a_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.cells_written != '0) |-> o_out_data.visited)
        else $error("updated cell not visited");

endmodule

bind occupancy_ray_grid_update orgu_checker u_orgu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

@@ bench/occupancy_ray_grid_update_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_ray_grid_update_tb
// Self-checking bench for the occupancy ray grid update block. A shadow grid
// predicts each result: free rays walked with Bresenham, occupied marks and
// reads. Results are compared field by field in order. Both handshake sides
// idle and stall in random bursts.
// ----------------------------------------------------------------------------
module occupancy_ray_grid_update_tb;
    import orgu_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 11;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYC  = 20;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    // shadow copy of the grid
    bit [CERT_W-1:0] cert_map [CELL_COUNT];
    bit              vis_map  [CELL_COUNT];
    bit              wall_map [CELL_COUNT];

    t_out_item pending_reports [$];
    t_out_item want_report;
    int        error_count = 0;
    int        cycle_count = 0;
    int        stall_burst = 0;
    bit        idle_on     = 1'b1;

    occupancy_ray_grid_update u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic t_out_item mark_cell(input int x, input int y, input bit occupied,
                                            input t_out_item acc);
        int        idx;
        int        old_c;
        int        new_c;
        t_out_item r;
        r = acc;
        if (x < 0 || x >= GRID_COLS || y < 0 || y >= GRID_ROWS) return r;
        idx   = y * GRID_COLS + x;
        old_c = cert_map[idx];
        if (occupied) new_c = (old_c + OCC_STEP > CERT_MAX) ? CERT_MAX : old_c + OCC_STEP;
        else          new_c = (old_c == 0) ? 0 : old_c - 1;
        vis_map[idx] = 1'b1;
        if (new_c >= CERT_MAX || old_c > WALL_OLD_LIMIT) wall_map[idx] = 1'b1;
        cert_map[idx]   = CERT_W'(new_c);
        r.certainty     = CERT_W'(new_c);
        r.visited       = 1'b1;
        r.wall          = wall_map[idx];
        r.cells_written = acc.cells_written + 1'b1;
        return r;
    endfunction

    function automatic t_out_item free_ray(input t_in_item item);
        int        x, y, x1, y1;
        int        dx, dy, stx, sty, p;
        t_out_item r;
        r   = '0;
        x   = item.start_x;
        y   = item.start_y;
        x1  = item.end_x;
        y1  = item.end_y;
        dx  = x1 - x;
        dy  = y1 - y;
        stx = 1;
        sty = 1;
        if (dx < 0) begin
            dx  = -dx;
            stx = -1;
        end
        if (dy < 0) begin
            dy  = -dy;
            sty = -1;
        end
        r = mark_cell(x, y, 1'b0, r);
        if (dx > dy) begin
            p = 2 * dy - dx;
            while (x != x1) begin
                x += stx;
                if (p < 0) begin
                    p += 2 * dy;
                end else begin
                    y += sty;
                    p += 2 * (dy - dx);
                end
                r = mark_cell(x, y, 1'b0, r);
            end
        end else begin
            p = 2 * dx - dy;
            while (y != y1) begin
                y += sty;
                if (p < 0) begin
                    p += 2 * dx;
                end else begin
                    x += stx;
                    p += 2 * (dx - dy);
                end
                r = mark_cell(x, y, 1'b0, r);
            end
        end
        return r;
    endfunction

    function automatic t_out_item apply_command(input t_in_item item);
        t_out_item r;
        int        idx;
        r = '0;
        if (item.command == CMD_RAY) begin
            r = free_ray(item);
        end else if (item.command == CMD_OCC) begin
            r = mark_cell(item.start_x, item.start_y, 1'b1, r);
        end else if (item.command == CMD_READ) begin
            if (item.start_x < GRID_COLS && item.start_y < GRID_ROWS) begin
                idx         = item.start_y * GRID_COLS + item.start_x;
                r.certainty = cert_map[idx];
                r.visited   = vis_map[idx];
                r.wall      = wall_map[idx];
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    function automatic t_in_item make_item(input t_cmd cmd, input int sx, input int sy,
                                           input int ex, input int ey);
        t_in_item item;
        item.command = cmd;
        item.start_x = COORD_W'(sx);
        item.start_y = COORD_W'(sy);
        item.end_x   = COORD_W'(ex);
        item.end_y   = COORD_W'(ey);
        return item;
    endfunction

    task automatic send_item(input t_in_item item);
        int          gap;
        logic [63:0] raw;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 1) == 1) begin
            gap        = $urandom_range(1, 18);
            raw        = {$urandom, $urandom};
            i_in_valid <= 1'b0;
            i_in_data  <= raw[$bits(t_in_item)-1:0];
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pending_reports.push_back(apply_command(item));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_out_stall <= 1'b0;
            stall_burst = 0;
        end else if (stall_burst == 0) begin
            stall_burst = $urandom_range(1, 18);
            i_out_stall <= 1'($urandom_range(0, 1));
        end else begin
            stall_burst--;
        end
    end

    task automatic compare_field(input string name, input logic [CNT_W-1:0] want_v,
                                 input logic [CNT_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: result transfer with none expected, expected nothing, got %p",
                         $time, o_out_data);
                error_count++;
            end else begin
                want_report = pending_reports.pop_front();
                compare_field("certainty", want_report.certainty, o_out_data.certainty);
                compare_field("visited", want_report.visited, o_out_data.visited);
                compare_field("wall", want_report.wall, o_out_data.wall);
                compare_field("cells_written", want_report.cells_written,
                              o_out_data.cells_written);
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_after_reset();
        send_item(make_item(CMD_READ, 0, 0, 0, 0));
        send_item(make_item(CMD_READ, 255, 255, 255, 255));
        send_item(make_item(CMD_NONE, 255, 255, 255, 255));
    endtask

    // 0, 3, 6, 9, 12 then clamp at 15 with the wall flag
    task automatic test_occupied_climb();
        repeat (5) send_item(make_item(CMD_OCC, 3, 4, 200, 100));
        send_item(make_item(CMD_READ, 3, 4, 0, 0));
    endtask

    // 11 + 3 gives 14 without a wall; the next free pass sets it from the old value
    task automatic test_wall_on_old_value();
        repeat (4) send_item(make_item(CMD_OCC, 9, 9, 0, 0));
        send_item(make_item(CMD_RAY, 9, 9, 9, 9));
        send_item(make_item(CMD_OCC, 9, 9, 0, 0));
        send_item(make_item(CMD_READ, 9, 9, 0, 0));
        send_item(make_item(CMD_RAY, 9, 9, 9, 9));
    endtask

    task automatic test_long_rays();
        send_item(make_item(CMD_RAY, 0, 4, 255, 4));
        send_item(make_item(CMD_RAY, 255, 255, 0, 0));
        send_item(make_item(CMD_RAY, 0, 0, 0, 255));
        send_item(make_item(CMD_RAY, 10, 200, 250, 3));
        send_item(make_item(CMD_RAY, 0, 255, 255, 0));
        send_item(make_item(CMD_READ, 3, 4, 0, 0));
    endtask

    // most items stay inside a small window so cells are hit again and again
    task automatic test_random_window(input int count, input int span, input int occ_pct);
        int          base_x;
        int          base_y;
        int          roll;
        logic [63:0] raw;
        t_in_item    item;
        base_x = $urandom_range(0, 255);
        base_y = $urandom_range(0, 255);
        for (int n = 0; n < count; n++) begin
            raw  = {$urandom, $urandom};
            item = raw[$bits(t_in_item)-1:0];
            roll = $urandom_range(0, 99);
            if (roll < occ_pct)                             item.command = CMD_OCC;
            else if (roll < occ_pct + (100 - occ_pct) * 2 / 3) item.command = CMD_RAY;
            else if (roll < 97)                             item.command = CMD_READ;
            else                                            item.command = CMD_NONE;
            if ($urandom_range(0, 99) < 85) begin
                item.start_x = COORD_W'(base_x + $urandom_range(0, span - 1));
                item.start_y = COORD_W'(base_y + $urandom_range(0, span - 1));
                item.end_x   = COORD_W'(base_x + $urandom_range(0, span - 1));
                item.end_y   = COORD_W'(base_y + $urandom_range(0, span - 1));
            end
            send_item(item);
        end
    endtask

    task automatic test_random_no_idle();
        idle_on = 1'b0;
        test_random_window(50, 8, 55);
    endtask

    initial begin
        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_occupied_climb();
        test_wall_on_old_value();
        test_long_rays();
        wait_for_results();
        test_random_window(220, 4, 50);
        wait_for_results();
        test_random_window(220, 8, 60);
        wait_for_results();
        test_random_window(200, 16, 45);
        wait_for_results();
        test_random_window(160, 8, 70);
        wait_for_results();
        test_random_no_idle();
        wait_for_results();

        repeat (SETTLE_CYC) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
